### sv/lspmd_pkg.sv
`default_nettype none
package lspmd_pkg;

  localparam int CHANNELS    = 8;
  localparam int SAMPLE_BITS = 12;
  localparam int NORM_BITS   = 10;
  localparam int NUM_W       = SAMPLE_BITS + NORM_BITS;
  localparam int DIV_STEPS   = NORM_BITS;
  localparam int STEP_W      = $clog2(DIV_STEPS + 1);

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};
  localparam logic [NORM_BITS-1:0]   NORM_FULL  = NORM_BITS'(1000);

  localparam int GAIN_W  = 24;
  localparam int ERR_W   = 14;
  localparam int SUM_W   = 32;
  localparam int CORR_W  = 16;
  localparam int SPEED_W = 10;
  localparam int PROD_W  = GAIN_W + SUM_W;
  localparam int ACC_W   = PROD_W + 2;

  localparam logic [SPEED_W-1:0] SPEED_MAX   = SPEED_W'(1000);
  localparam logic [GAIN_W-1:0]  GAIN_P_INIT = GAIN_W'(6554);
  localparam logic [SPEED_W-1:0] BASE_INIT   = SPEED_W'(500);

  // Item commands. The last code is unused and does nothing.
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_CAL   = 2'd1;
  localparam logic [1:0] CMD_RUN   = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  // Register indexes.
  localparam logic [1:0] REG_GAIN_P = 2'd0;
  localparam logic [1:0] REG_GAIN_I = 2'd1;
  localparam logic [1:0] REG_GAIN_D = 2'd2;
  localparam logic [1:0] REG_BASE   = 2'd3;

  typedef struct packed {
    logic       load;
    logic [1:0] cmd;
    logic       step;
  } lane_ctrl_t;

  typedef struct packed {
    logic start;
    logic take;
  } pid_ctrl_t;

  typedef enum logic [1:0] {C_IDLE, C_NORM, C_MERGE, C_PID} ctl_state_t;
  typedef enum logic [1:0] {P_IDLE, P_MUL, P_CORR, P_DONE} pid_state_t;

endpackage
`default_nettype wire

### sv/lspmd_lane.sv
`default_nettype none
module lspmd_lane (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire lspmd_pkg::lane_ctrl_t                 ctrl,
  input  wire logic [lspmd_pkg::SAMPLE_BITS-1:0]     raw,
  output logic      [lspmd_pkg::NORM_BITS-1:0]       value
);

  logic [lspmd_pkg::SAMPLE_BITS-1:0] chan_min;
  logic [lspmd_pkg::SAMPLE_BITS-1:0] chan_max;
  logic [lspmd_pkg::NUM_W-1:0]       rem;
  logic [lspmd_pkg::NUM_W-1:0]       dsh;
  logic [lspmd_pkg::NORM_BITS-1:0]   quo;
  logic                              is_zero;
  logic                              is_full;

  logic signed [lspmd_pkg::SAMPLE_BITS:0] diff;
  logic signed [lspmd_pkg::SAMPLE_BITS:0] range;
  logic [lspmd_pkg::SAMPLE_BITS-1:0]      range_eff;
  logic [lspmd_pkg::NORM_BITS-1:0]        norm;

  // Offset and calibrated range for the sample being loaded.
  always_comb begin
    diff  = $signed({1'b0, raw}) - $signed({1'b0, chan_min});
    range = $signed({1'b0, chan_max}) - $signed({1'b0, chan_min});
    if (range <= 0) begin
      range_eff = lspmd_pkg::SAMPLE_BITS'(1);
    end else begin
      range_eff = range[lspmd_pkg::SAMPLE_BITS-1:0];
    end
  end

  // Calibration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      chan_min <= '0;
      chan_max <= lspmd_pkg::SAMPLE_MAX;
    end else if (ctrl.load) begin
      case (ctrl.cmd)
        lspmd_pkg::CMD_CLEAR: begin
          chan_min <= lspmd_pkg::SAMPLE_MAX;
          chan_max <= '0;
        end
        lspmd_pkg::CMD_CAL: begin
          if (raw < chan_min) chan_min <= raw;
          if (raw > chan_max) chan_max <= raw;
        end
        default: ;
      endcase
    end
  end

  // Restoring division, one quotient bit a step. Out-of-range offsets
  // are settled at load and the division result is then ignored.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      is_zero <= (diff <= 0);
      is_full <= (diff >= $signed({1'b0, range_eff}));
      rem     <= lspmd_pkg::NUM_W'(diff[lspmd_pkg::SAMPLE_BITS-1:0])
                 * lspmd_pkg::NUM_W'(1000);
      dsh     <= lspmd_pkg::NUM_W'(range_eff) << (lspmd_pkg::DIV_STEPS - 1);
      quo     <= '0;
    end else if (ctrl.step) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        quo <= {quo[lspmd_pkg::NORM_BITS-2:0], 1'b1};
      end else begin
        quo <= {quo[lspmd_pkg::NORM_BITS-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

  always_comb begin
    if (is_zero) begin
      norm = '0;
    end else if (is_full) begin
      norm = lspmd_pkg::NORM_FULL;
    end else begin
      norm = quo;
    end
    value = lspmd_pkg::NORM_FULL - norm;
  end

endmodule
`default_nettype wire

### sv/lspmd_pid.sv
`default_nettype none
module lspmd_pid (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire lspmd_pkg::pid_ctrl_t                     ctrl,
  input  wire logic signed [lspmd_pkg::ERR_W-1:0]       err,
  input  wire logic signed [lspmd_pkg::GAIN_W-1:0]      gain_p,
  input  wire logic signed [lspmd_pkg::GAIN_W-1:0]      gain_i,
  input  wire logic signed [lspmd_pkg::GAIN_W-1:0]      gain_d,
  input  wire logic        [lspmd_pkg::SPEED_W-1:0]     cruise,
  output logic                                          done,
  output logic signed      [lspmd_pkg::CORR_W-1:0]      corr,
  output logic             [lspmd_pkg::SPEED_W-1:0]     left,
  output logic             [lspmd_pkg::SPEED_W-1:0]     right
);

  lspmd_pkg::pid_state_t state, state_next;

  logic signed [lspmd_pkg::SUM_W-1:0]  error_sum;
  logic signed [lspmd_pkg::ERR_W-1:0]  prev_error;
  logic signed [lspmd_pkg::SUM_W-1:0]  sum_op;
  logic signed [lspmd_pkg::ERR_W:0]    deriv_op;
  logic signed [lspmd_pkg::ERR_W-1:0]  err_op;
  logic signed [lspmd_pkg::PROD_W-1:0] prod;
  logic signed [lspmd_pkg::ACC_W-1:0]  acc;
  logic [1:0]                          cnt;

  logic signed [lspmd_pkg::SUM_W:0]    sum_wide;
  logic signed [lspmd_pkg::SUM_W-1:0]  sum_sat;
  logic signed [lspmd_pkg::GAIN_W-1:0] mul_a;
  logic signed [lspmd_pkg::SUM_W-1:0]  mul_b;
  logic signed [lspmd_pkg::ACC_W-1:0]  acc_adj;
  logic signed [lspmd_pkg::ACC_W-17:0] acc_q;
  logic signed [lspmd_pkg::CORR_W+2:0] left_w;
  logic signed [lspmd_pkg::CORR_W+2:0] right_w;

  // Saturating integral update.
  always_comb begin
    sum_wide = $signed({error_sum[lspmd_pkg::SUM_W-1], error_sum})
             + (lspmd_pkg::SUM_W+1)'(err);
    if (sum_wide[lspmd_pkg::SUM_W] != sum_wide[lspmd_pkg::SUM_W-1]) begin
      sum_sat = sum_wide[lspmd_pkg::SUM_W] ? {1'b1, {(lspmd_pkg::SUM_W-1){1'b0}}}
                                            : {1'b0, {(lspmd_pkg::SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[lspmd_pkg::SUM_W-1:0];
    end
  end

  // Shared multiplier operand select: P, then I, then D term.
  always_comb begin
    case (cnt)
      2'd0: begin
        mul_a = gain_p;
        mul_b = lspmd_pkg::SUM_W'(err_op);
      end
      2'd1: begin
        mul_a = gain_i;
        mul_b = sum_op;
      end
      2'd2: begin
        mul_a = gain_d;
        mul_b = lspmd_pkg::SUM_W'(deriv_op);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lspmd_pkg::P_IDLE;
      error_sum  <= '0;
      prev_error <= '0;
      cnt        <= '0;
    end else begin
      state <= state_next;
      if (ctrl.start) begin
        error_sum  <= sum_sat;
        prev_error <= err;
        cnt        <= '0;
      end else if (state == lspmd_pkg::P_MUL) begin
        cnt <= cnt + 2'd1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      err_op   <= err;
      sum_op   <= sum_sat;
      deriv_op <= $signed({err[lspmd_pkg::ERR_W-1], err})
                - $signed({prev_error[lspmd_pkg::ERR_W-1], prev_error});
      acc      <= '0;
    end else if (state == lspmd_pkg::P_MUL) begin
      prod <= mul_a * mul_b;
      if (cnt != 2'd0) begin
        acc <= acc + {{2{prod[lspmd_pkg::PROD_W-1]}}, prod};
      end
    end
    if (state == lspmd_pkg::P_CORR) begin
      if (acc_q > 32767) begin
        corr <= 16'sh7FFF;
      end else if (acc_q < -32768) begin
        corr <= 16'sh8000;
      end else begin
        corr <= acc_q[lspmd_pkg::CORR_W-1:0];
      end
    end
  end

  // Division by 65536 toward zero.
  always_comb begin
    acc_adj = acc[lspmd_pkg::ACC_W-1] ? acc + lspmd_pkg::ACC_W'(65535) : acc;
    acc_q   = acc_adj[lspmd_pkg::ACC_W-1:16];
  end

  // Motor duties.
  always_comb begin
    left_w  = $signed({9'b0, cruise}) + (lspmd_pkg::CORR_W+3)'(corr);
    right_w = $signed({9'b0, cruise}) - (lspmd_pkg::CORR_W+3)'(corr);
    if (left_w < 0) begin
      left = '0;
    end else if (left_w > $signed({9'b0, lspmd_pkg::SPEED_MAX})) begin
      left = lspmd_pkg::SPEED_MAX;
    end else begin
      left = left_w[lspmd_pkg::SPEED_W-1:0];
    end
    if (right_w < 0) begin
      right = '0;
    end else if (right_w > $signed({9'b0, lspmd_pkg::SPEED_MAX})) begin
      right = lspmd_pkg::SPEED_MAX;
    end else begin
      right = right_w[lspmd_pkg::SPEED_W-1:0];
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    done       = 1'b0;
    case (state)
      lspmd_pkg::P_IDLE: begin
        if (ctrl.start) state_next = lspmd_pkg::P_MUL;
      end
      lspmd_pkg::P_MUL: begin
        if (cnt == 2'd3) state_next = lspmd_pkg::P_CORR;
      end
      lspmd_pkg::P_CORR: begin
        state_next = lspmd_pkg::P_DONE;
      end
      lspmd_pkg::P_DONE: begin
        done = 1'b1;
        if (ctrl.take) state_next = lspmd_pkg::P_IDLE;
      end
      default: state_next = lspmd_pkg::P_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### sv/line_sensor_pid_motor_drive.sv
// Line-sensor PID motor drive.
// Input channel (in_valid/in_stall) carries cmd and eight samples. A clear
// or calibration transaction is taken without stalling the input and gives no result.
// A control transaction runs the eight channel lanes side by side: each
// normalizes its sample with a restoring divider, one quotient bit per
// cycle. The merge state then forms the line error, and the PID unit
// takes its three products through one shared multiplier and then
// scales and saturates the correction. A new item is taken only once
// the previous control step has moved into the output register; with no
// control step in flight, a calibration item is taken every cycle, which
// is the sustained rate.
// Output channel (out_valid/out_stall): a valid result holds while
// out_stall is high; a finished step waits in the PID unit until it frees.
// Configuration (cfg_valid/cfg_ready) is always ready; write only when idle.
// Synchronous reset restores calibration (min 0, max full scale), clears
// the integral and previous error, and loads the default gains and speed.
`default_nettype none
module line_sensor_pid_motor_drive (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [1:0]                            cmd,
  input  wire logic [lspmd_pkg::SAMPLE_BITS-1:0]     raw_0,
  input  wire logic [lspmd_pkg::SAMPLE_BITS-1:0]     raw_1,
  input  wire logic [lspmd_pkg::SAMPLE_BITS-1:0]     raw_2,
  input  wire logic [lspmd_pkg::SAMPLE_BITS-1:0]     raw_3,
  input  wire logic [lspmd_pkg::SAMPLE_BITS-1:0]     raw_4,
  input  wire logic [lspmd_pkg::SAMPLE_BITS-1:0]     raw_5,
  input  wire logic [lspmd_pkg::SAMPLE_BITS-1:0]     raw_6,
  input  wire logic [lspmd_pkg::SAMPLE_BITS-1:0]     raw_7,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [lspmd_pkg::ERR_W-1:0]         line_error,
  output logic signed [lspmd_pkg::CORR_W-1:0]        correction,
  output logic        [lspmd_pkg::SPEED_W-1:0]       left_duty,
  output logic        [lspmd_pkg::SPEED_W-1:0]       right_duty,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [1:0]                            cfg_index,
  input  wire logic [lspmd_pkg::GAIN_W-1:0]          cfg_data
);

  lspmd_pkg::ctl_state_t state, state_next;

  logic signed [lspmd_pkg::GAIN_W-1:0]  gain_p;
  logic signed [lspmd_pkg::GAIN_W-1:0]  gain_i;
  logic signed [lspmd_pkg::GAIN_W-1:0]  gain_d;
  logic        [lspmd_pkg::SPEED_W-1:0] cruise;
  logic        [lspmd_pkg::STEP_W-1:0]  step_cnt;
  logic signed [lspmd_pkg::ERR_W-1:0]   err;

  logic                                 accept;
  logic                                 load_out;
  logic                                 pid_done;
  logic signed [lspmd_pkg::CORR_W-1:0]  pid_corr;
  logic        [lspmd_pkg::SPEED_W-1:0] pid_left;
  logic        [lspmd_pkg::SPEED_W-1:0] pid_right;
  lspmd_pkg::lane_ctrl_t                lane_ctrl;
  lspmd_pkg::pid_ctrl_t                 pid_ctrl;
  logic [lspmd_pkg::SAMPLE_BITS-1:0]    raw  [lspmd_pkg::CHANNELS];
  logic [lspmd_pkg::NORM_BITS-1:0]      val  [lspmd_pkg::CHANNELS];
  logic signed [lspmd_pkg::ERR_W:0]     wsum;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != lspmd_pkg::C_IDLE);
  assign cfg_ready = 1'b1;
  assign load_out  = pid_done && (!out_valid || !out_stall);

  assign raw[0] = raw_0;
  assign raw[1] = raw_1;
  assign raw[2] = raw_2;
  assign raw[3] = raw_3;
  assign raw[4] = raw_4;
  assign raw[5] = raw_5;
  assign raw[6] = raw_6;
  assign raw[7] = raw_7;

  assign lane_ctrl.load = accept;
  assign lane_ctrl.cmd  = cmd;
  assign lane_ctrl.step = (state == lspmd_pkg::C_NORM);

  // Channel lanes.
  for (genvar g = 0; g < lspmd_pkg::CHANNELS; g++) begin : g_lane
    lspmd_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (lane_ctrl),
      .raw   (raw[g]),
      .value (val[g])
    );
  end

  // Merge: doubled weights -5,-3,-1,1,3,5 on channels 1..6, then halve
  // toward zero.
  always_comb begin
    wsum = 15'sd5 * ($signed({5'b0, val[6]}) - $signed({5'b0, val[1]}))
         + 15'sd3 * ($signed({5'b0, val[5]}) - $signed({5'b0, val[2]}))
         + ($signed({5'b0, val[4]}) - $signed({5'b0, val[3]}));
  end

  always_ff @(posedge clk) begin
    if (state == lspmd_pkg::C_MERGE) begin
      err <= lspmd_pkg::ERR_W'((wsum + (wsum[lspmd_pkg::ERR_W] ? 15'sd1 : 15'sd0)) >>> 1);
    end
  end

  assign pid_ctrl.start = (state == lspmd_pkg::C_MERGE) ? 1'b0 :
                          (state == lspmd_pkg::C_PID) && (step_cnt == '0);
  assign pid_ctrl.take  = load_out;

  lspmd_pid u_pid (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (pid_ctrl),
    .err        (err),
    .gain_p     (gain_p),
    .gain_i     (gain_i),
    .gain_d     (gain_d),
    .cruise     (cruise),
    .done       (pid_done),
    .corr       (pid_corr),
    .left       (pid_left),
    .right      (pid_right)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p <= lspmd_pkg::GAIN_P_INIT;
      gain_i <= '0;
      gain_d <= '0;
      cruise <= lspmd_pkg::BASE_INIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lspmd_pkg::REG_GAIN_P: gain_p <= cfg_data;
        lspmd_pkg::REG_GAIN_I: gain_i <= cfg_data;
        lspmd_pkg::REG_GAIN_D: gain_d <= cfg_data;
        lspmd_pkg::REG_BASE:   cruise <= cfg_data[lspmd_pkg::SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state and step counter. In C_PID the counter marks the first
  // cycle so the PID unit is started once.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lspmd_pkg::C_IDLE;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (state_next != state) begin
        step_cnt <= '0;
      end else if (step_cnt != lspmd_pkg::STEP_W'(lspmd_pkg::DIV_STEPS)) begin
        step_cnt <= step_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lspmd_pkg::C_IDLE: begin
        if (accept && (cmd == lspmd_pkg::CMD_RUN)) state_next = lspmd_pkg::C_NORM;
      end
      lspmd_pkg::C_NORM: begin
        if (step_cnt == lspmd_pkg::STEP_W'(lspmd_pkg::DIV_STEPS - 1)) begin
          state_next = lspmd_pkg::C_MERGE;
        end
      end
      lspmd_pkg::C_MERGE: begin
        state_next = lspmd_pkg::C_PID;
      end
      lspmd_pkg::C_PID: begin
        if (load_out) state_next = lspmd_pkg::C_IDLE;
      end
      default: state_next = lspmd_pkg::C_IDLE;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      line_error <= err;
      correction <= pid_corr;
      left_duty  <= pid_left;
      right_duty <= pid_right;
    end
  end

  // A control transaction stalls the input after it is accepted.
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd == lspmd_pkg::CMD_RUN) |=> in_stall)
    else $error("input not stalled after control transaction");

  // A result is only loaded while a control step is in flight.
  a_load_in_pid: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (state == lspmd_pkg::C_PID))
    else $error("result loaded outside control step");

  // Motor duties stay within range.
  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (left_duty <= lspmd_pkg::SPEED_MAX) &&
                  (right_duty <= lspmd_pkg::SPEED_MAX))
    else $error("motor duty out of range");

endmodule
`default_nettype wire
